/* rtl/core/wmal_pkg.sv */
package wmal_pkg;

    localparam int NCH = 6;
    localparam int CH_BITS = 3;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COLLECT = 2'd1;
    localparam logic [1:0] MODE_RUN     = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam logic [0:0] REG_MODE  = 1'd0;
    localparam logic [0:0] REG_ALPHA = 1'd1;

    localparam logic [16:0] ALPHA_RESET = 17'd6554;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV,
        ST_INTEG,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic read_old;
        logic update;
        logic div_start;
        logic integ;
        logic next_ch;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_ch;
    } ctrl_status_t;

endpackage

/* rtl/core/wmal_ctrl.sv */
module wmal_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [1:0]            mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wmal_pkg::ctrl_cmd_t    cmd,
    input  wmal_pkg::ctrl_status_t status
);
    import wmal_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic run_reg, run_next;
    logic out_valid_reg, out_valid_next;
    logic fire;
    logic active;

    assign fire = in_valid && in_ready;
    assign active = (mode == MODE_COLLECT) || (mode == MODE_RUN);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire && func == FUNC_SAMPLE && active)
                begin
                    state_next = ST_READ;
                    run_next   = (mode == MODE_RUN);
                end
            end
            ST_READ:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = run_reg ? ST_DIV_START : ST_IDLE;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:       state_next = status.div_done ? ST_INTEG : ST_DIV;
            ST_INTEG:     state_next = status.last_ch ? ST_OUT : ST_DIV;
            ST_OUT:       state_next = (out_valid_reg && !out_ready) ? ST_OUT : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.clear = fire && func == FUNC_CLEAR;
                cmd.start = fire && func == FUNC_SAMPLE && active;
            end
            ST_READ:      cmd.read_old = 1'b1;
            ST_UPDATE:    cmd.update = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV:       ;
            ST_INTEG:
            begin
                cmd.integ     = 1'b1;
                cmd.next_ch   = 1'b1;
                cmd.div_start = !status.last_ch;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/wmal_datapath.sv */
module wmal_datapath #(
    parameter int WINDOW      = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wmal_pkg::ctrl_cmd_t            cmd,
    output wmal_pkg::ctrl_status_t         status,
    input  logic [16:0]                   alpha,
    input  logic signed [SAMPLE_BITS-1:0] sample_in [wmal_pkg::NCH],
    output logic signed [SAMPLE_BITS-1:0] result [wmal_pkg::NCH]
);
    import wmal_pkg::*;

    localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_BITS = $clog2(WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + FILL_BITS + 1;
    localparam int ST_BITS   = SAMPLE_BITS + 17;
    localparam int DIFF_BITS = ST_BITS + 2;
    localparam int PROD_BITS = DIFF_BITS + 18;
    localparam int QBITS     = SUM_BITS;
    localparam int DBITS     = FILL_BITS;

    logic signed [SAMPLE_BITS-1:0] hist_mem [NCH][WINDOW];
    logic signed [SAMPLE_BITS-1:0] sample_reg [NCH];
    logic signed [SAMPLE_BITS-1:0] old_reg [NCH];
    logic signed [SUM_BITS-1:0]    sum_reg [NCH];
    logic signed [ST_BITS-1:0]     smooth_reg [NCH];
    logic signed [SAMPLE_BITS-1:0] result_reg [NCH];
    logic [FILL_BITS-1:0]          fill_reg;
    logic [SLOT_BITS-1:0]          slot_reg;
    logic [CH_BITS-1:0]            ch_reg;
    logic                          full;

    logic [QBITS-1:0]              rem_reg, quo_reg;
    logic                          div_busy_reg, div_done_reg, div_neg_reg;
    logic [QBITS-1:0]              dividend_abs;
    logic [QBITS:0]                trial;
    logic [DBITS+1:0]              step_reg;

    logic signed [SUM_BITS:0]      mean;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [PROD_BITS-1:0]   prod;
    logic [16:0]                   gain;

    assign full = (fill_reg == FILL_BITS'(WINDOW));
    assign status.div_done = div_done_reg;
    assign status.last_ch  = (ch_reg == CH_BITS'(NCH - 1));
    assign result = result_reg;
    assign gain = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCH; c++)
        begin
            if (cmd.start)
                sample_reg[c] <= sample_in[c];
            if (cmd.read_old)
                old_reg[c] <= hist_mem[c][slot_reg];
            if (cmd.update)
                hist_mem[c][slot_reg] <= sample_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            slot_reg <= '0;
            ch_reg   <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c]    <= '0;
                smooth_reg[c] <= '0;
                result_reg[c] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                fill_reg <= '0;
                slot_reg <= '0;
                for (int c = 0; c < NCH; c++)
                    sum_reg[c] <= '0;
            end
            if (cmd.update)
            begin
                for (int c = 0; c < NCH; c++)
                    sum_reg[c] <= sum_reg[c] + SUM_BITS'(sample_reg[c])
                                  - (full ? SUM_BITS'(old_reg[c]) : '0);
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
                slot_reg <= (slot_reg == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                ch_reg <= '0;
            end
            if (cmd.integ)
                smooth_reg[ch_reg] <= smooth_reg[ch_reg] + ST_BITS'(prod >>> 16);
            if (cmd.next_ch && !status.last_ch)
                ch_reg <= ch_reg + 1'b1;
            if (cmd.finish)
                for (int c = 0; c < NCH; c++)
                    result_reg[c] <= SAMPLE_BITS'((smooth_reg[c] +
                        ((smooth_reg[c] < 0) ? ST_BITS'(65535) : '0)) >>> 16);
        end
    end

    // Restoring divider on the magnitude of the window sum, one bit a cycle.
    always_comb
    begin
        dividend_abs = sum_reg[ch_reg + (cmd.div_start && cmd.next_ch ? 1'b1 : 1'b0)] < 0
            ? QBITS'(-sum_reg[ch_reg + (cmd.div_start && cmd.next_ch ? 1'b1 : 1'b0)])
            : QBITS'(sum_reg[ch_reg + (cmd.div_start && cmd.next_ch ? 1'b1 : 1'b0)]);
        trial = {rem_reg, quo_reg[QBITS-1]} - {{(QBITS+1-DBITS){1'b0}}, fill_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            step_reg     <= '0;
            div_neg_reg  <= 1'b0;
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                step_reg     <= (DBITS+2)'(QBITS);
                rem_reg      <= '0;
                quo_reg      <= dividend_abs;
                div_neg_reg  <= sum_reg[ch_reg + (cmd.next_ch ? 1'b1 : 1'b0)] < 0;
            end
            else if (div_busy_reg)
            begin
                if (!trial[QBITS])
                begin
                    rem_reg <= trial[QBITS-1:0];
                    quo_reg <= {quo_reg[QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[QBITS-2:0], quo_reg[QBITS-1]};
                    quo_reg <= {quo_reg[QBITS-2:0], 1'b0};
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == (DBITS+2)'(1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        mean = div_neg_reg ? -$signed({2'b00, quo_reg[QBITS-2:0]})
                           : $signed({2'b00, quo_reg[QBITS-2:0]});
        diff = (DIFF_BITS'(mean) <<< 16) - DIFF_BITS'(smooth_reg[ch_reg]);
        prod = PROD_BITS'(diff) * $signed({1'b0, gain});
    end

endmodule

/* rtl/core/wrench_moving_average_lowpass.sv */
// Six-channel force/torque conditioner: a moving average over up to WINDOW
// samples per channel, followed by a leaky integrator with gain alpha (Q1.16,
// clamped to 1.0). In run mode the time to a result is set by the shared
// bit-serial divider that forms each channel mean in turn. The next request
// can be taken in the same cycle that the result is offered, while the result
// waits in its output register, and a finished result is held back only
// while the previous one has not been taken. Collect-mode samples pass
// through the read and update states only, and clear requests are handled
// in the idle state. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
module wrench_moving_average_lowpass #(
    parameter int WINDOW      = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [16:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [SAMPLE_BITS-1:0] force_x,
    input  logic signed [SAMPLE_BITS-1:0] force_y,
    input  logic signed [SAMPLE_BITS-1:0] force_z,
    input  logic signed [SAMPLE_BITS-1:0] moment_x,
    input  logic signed [SAMPLE_BITS-1:0] moment_y,
    input  logic signed [SAMPLE_BITS-1:0] moment_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_force_x,
    output logic signed [SAMPLE_BITS-1:0] out_force_y,
    output logic signed [SAMPLE_BITS-1:0] out_force_z,
    output logic signed [SAMPLE_BITS-1:0] out_torque_x,
    output logic signed [SAMPLE_BITS-1:0] out_torque_y,
    output logic signed [SAMPLE_BITS-1:0] out_torque_z
);
    import wmal_pkg::*;

    logic [1:0]                    mode_reg;
    logic [16:0]                   alpha_reg;
    ctrl_cmd_t                     cmd;
    ctrl_status_t                  status;
    logic signed [SAMPLE_BITS-1:0] samples [NCH];
    logic signed [SAMPLE_BITS-1:0] results [NCH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_ALPHA: alpha_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign samples[0] = force_x;
    assign samples[1] = force_y;
    assign samples[2] = force_z;
    assign samples[3] = moment_x;
    assign samples[4] = moment_y;
    assign samples[5] = moment_z;
    assign out_force_x  = results[0];
    assign out_force_y  = results[1];
    assign out_force_z  = results[2];
    assign out_torque_x = results[3];
    assign out_torque_y = results[4];
    assign out_torque_z = results[5];

    wmal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .mode      (mode_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    wmal_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .alpha     (alpha_reg),
        .sample_in (samples),
        .result    (results)
    );

endmodule

/* rtl/core/wmal_checker.sv */
module wmal_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [23:0] out_force_x
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_force_x))
        else $error("result dropped or changed while stalled");

    a_gap_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared straight after a request");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_force_x))
        else $error("result offered with unknown bits");

endmodule

bind wrench_moving_average_lowpass wmal_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_force_x (out_force_x)
);
